// File: src/rfa_pkg.sv
// Shared types and constants for the rational fraction ALU.
package rfa_pkg;

   // Fixed field widths
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned NUM_W   = 64;
   localparam int unsigned DEN_W   = 63;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned ERR_W   = 2;

   // Default operand width used from each input field
   localparam int unsigned DEF_WIDTH = 32;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_LT  = 3'd4,
      KIND_LE  = 3'd5,
      KIND_GT  = 3'd6,
      KIND_GE  = 3'd7
   } kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK       = 2'd0,
      ERR_ZERO_DEN = 2'd1,
      ERR_DIV_ZERO = 2'd2,
      ERR_OVERFLOW = 2'd3
   } err_type;

endpackage

// File: src/rational_fraction_alu_core.sv
// Rational fraction ALU: add, sub, mul, div with gcd reduction and exact compares.
// One item at a time. Operands are the low WIDTH bits, read as signed. The three
// magnitude products come from one registered multiplier; compares then finish in
// the combine, compare and result steps. Arithmetic results are reduced by a
// binary gcd unit (one shift or subtract per cycle) and by two passes of a
// restoring divider. Items with a zero denominator or a zero divisor go straight
// to the result step. A new item is taken while the previous result still waits
// in the output register.
module rational_fraction_alu_core #(
   parameter int unsigned WIDTH = rfa_pkg::DEF_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [rfa_pkg::KIND_W-1:0] req_kind,
   input  logic [rfa_pkg::DATA_W-1:0] req_a_num,
   input  logic [rfa_pkg::DATA_W-1:0] req_a_den,
   input  logic [rfa_pkg::DATA_W-1:0] req_b_num,
   input  logic [rfa_pkg::DATA_W-1:0] req_b_den,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rfa_pkg::NUM_W-1:0]  rsp_res_num,
   output logic [rfa_pkg::DEN_W-1:0]  rsp_res_den,
   output logic                       rsp_cmp_true,
   output logic [rfa_pkg::ERR_W-1:0]  rsp_error
);
   import rfa_pkg::*;

   localparam int unsigned PW = 2 * WIDTH;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_MUL_D, ST_COMB, ST_CMP,
      ST_GCD_GO, ST_GCD_WAIT, ST_DIVN_GO, ST_DIVN_WAIT, ST_DIVD_GO, ST_DIVD_WAIT,
      ST_FIN
   } state_type;

   state_type        state_ff, state_in;
   kind_type         kind_ff, kind_in;
   err_type          err_ff, err_in;
   logic             cmp_ff, cmp_in;
   logic [WIDTH-1:0] anm_ff, anm_in, adm_ff, adm_in, bnm_ff, bnm_in, bdm_ff, bdm_in;
   logic             aneg_ff, aneg_in, bneg_ff, bneg_in;
   logic [PW-1:0]    p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in;
   logic [PW-1:0]    mag_ff, mag_in, den_ff, den_in, g_ff, g_in;
   logic             neg_ff, neg_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0] rsp_num_ff, rsp_num_in;
   logic [DEN_W-1:0] rsp_den_ff, rsp_den_in;
   logic             rsp_cmp_ff, rsp_cmp_in;
   err_type          rsp_err_ff, rsp_err_in;

   logic [WIDTH-1:0] x_an, x_ad, x_bn, x_bd;
   logic [WIDTH-1:0] mul_a, mul_b;
   logic [PW-1:0]    prod;
   logic             gcd_done, div_done;
   logic [PW-1:0]    gcd_g, div_q, div_n;
   logic             is_cmp, sb, lt, eq, ovf, accept, out_free;
   logic [NUM_W-1:0] mag64, den64;

   assign x_an = req_a_num[WIDTH-1:0];
   assign x_ad = req_a_den[WIDTH-1:0];
   assign x_bn = req_b_num[WIDTH-1:0];
   assign x_bd = req_b_den[WIDTH-1:0];

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_cmp   = (kind_ff == KIND_LT) || (kind_ff == KIND_LE) ||
                     (kind_ff == KIND_GT) || (kind_ff == KIND_GE);
   assign sb       = bneg_ff ^ (kind_ff == KIND_SUB);
   assign lt       = $signed(mag_ff) < $signed(den_ff);
   assign eq       = mag_ff == den_ff;
   assign mag64    = NUM_W'(mag_ff);
   assign den64    = NUM_W'(den_ff);
   assign ovf      = mag64[NUM_W-1] && (!neg_ff || (mag64[NUM_W-2:0] != '0));

   // multiplier operand select per product step
   always_comb begin
      unique case (state_ff)
         ST_MUL_A: begin
            mul_a = anm_ff;
            mul_b = (kind_ff == KIND_MUL) ? bnm_ff : bdm_ff;
         end
         ST_MUL_B: begin
            if (kind_ff == KIND_MUL) begin
               mul_a = adm_ff;
               mul_b = bdm_ff;
            end else if (kind_ff == KIND_DIV) begin
               mul_a = adm_ff;
               mul_b = bnm_ff;
            end else begin
               mul_a = bnm_ff;
               mul_b = adm_ff;
            end
         end
         default: begin
            mul_a = adm_ff;
            mul_b = bdm_ff;
         end
      endcase
   end

   assign div_n = (state_ff == ST_DIVD_GO) ? den_ff : mag_ff;

   rfa_mul #(.WIDTH(WIDTH)) u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   rfa_gcd #(.VAL_W(PW)) u_gcd (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_GCD_GO),
      .x     (mag_ff),
      .y     (den_ff),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rfa_div #(.VAL_W(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    ((state_ff == ST_DIVN_GO) || (state_ff == ST_DIVD_GO)),
      .dividend (div_n),
      .divisor  (g_ff),
      .done     (div_done),
      .quo      (div_q)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      err_in       = err_ff;
      cmp_in       = cmp_ff;
      anm_in       = anm_ff;
      adm_in       = adm_ff;
      bnm_in       = bnm_ff;
      bdm_in       = bdm_ff;
      aneg_in      = aneg_ff;
      bneg_in      = bneg_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p3_in        = p3_ff;
      mag_in       = mag_ff;
      den_in       = den_ff;
      g_in         = g_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_err_in   = rsp_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = kind_type'(req_kind);
               anm_in  = x_an[WIDTH-1] ? (~x_an + WIDTH'(1)) : x_an;
               adm_in  = x_ad[WIDTH-1] ? (~x_ad + WIDTH'(1)) : x_ad;
               bnm_in  = x_bn[WIDTH-1] ? (~x_bn + WIDTH'(1)) : x_bn;
               bdm_in  = x_bd[WIDTH-1] ? (~x_bd + WIDTH'(1)) : x_bd;
               aneg_in = (x_an[WIDTH-1] != x_ad[WIDTH-1]) && (x_an != '0);
               bneg_in = (x_bn[WIDTH-1] != x_bd[WIDTH-1]) && (x_bn != '0);
               cmp_in  = 1'b0;
               if ((x_ad == '0) || (x_bd == '0)) begin
                  err_in   = ERR_ZERO_DEN;
                  state_in = ST_FIN;
               end else if ((kind_type'(req_kind) == KIND_DIV) && (x_bn == '0)) begin
                  err_in   = ERR_DIV_ZERO;
                  state_in = ST_FIN;
               end else begin
                  err_in   = ERR_OK;
                  state_in = ST_MUL_A;
               end
            end
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: begin
            p1_in    = prod;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            p2_in    = prod;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            p3_in    = prod;
            state_in = ST_COMB;
         end
         ST_COMB: begin
            if (is_cmp) begin
               // signed cross products of the two fractions
               mag_in   = aneg_ff ? (~p1_ff + PW'(1)) : p1_ff;
               den_in   = bneg_ff ? (~p2_ff + PW'(1)) : p2_ff;
               state_in = ST_CMP;
            end else begin
               if ((kind_ff == KIND_ADD) || (kind_ff == KIND_SUB)) begin
                  den_in = p3_ff;
                  if (aneg_ff == sb) begin
                     mag_in = p1_ff + p2_ff;
                     neg_in = aneg_ff;
                  end else if (p1_ff >= p2_ff) begin
                     mag_in = p1_ff - p2_ff;
                     neg_in = aneg_ff;
                  end else begin
                     mag_in = p2_ff - p1_ff;
                     neg_in = sb;
                  end
               end else begin
                  mag_in = p1_ff;
                  den_in = p2_ff;
                  neg_in = aneg_ff ^ bneg_ff;
               end
               state_in = ST_GCD_GO;
            end
         end
         ST_CMP: begin
            case (kind_ff)
               KIND_LT: cmp_in = lt;
               KIND_LE: cmp_in = lt || eq;
               KIND_GT: cmp_in = !lt && !eq;
               default: cmp_in = !lt;
            endcase
            state_in = ST_FIN;
         end
         ST_GCD_GO: begin
            if (mag_ff == '0) begin
               neg_in = 1'b0;
            end
            state_in = ST_GCD_WAIT;
         end
         ST_GCD_WAIT: begin
            if (gcd_done) begin
               g_in     = gcd_g;
               state_in = ST_DIVN_GO;
            end
         end
         ST_DIVN_GO: state_in = ST_DIVN_WAIT;
         ST_DIVN_WAIT: begin
            if (div_done) begin
               mag_in   = div_q;
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: state_in = ST_DIVD_WAIT;
         ST_DIVD_WAIT: begin
            if (div_done) begin
               den_in   = div_q;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = '0;
               rsp_den_in   = '0;
               rsp_cmp_in   = 1'b0;
               rsp_err_in   = err_ff;
               if (err_ff == ERR_OK) begin
                  if (is_cmp) begin
                     rsp_cmp_in = cmp_ff;
                  end else if (ovf) begin
                     rsp_err_in = ERR_OVERFLOW;
                  end else begin
                     rsp_num_in = neg_ff ? (~mag64 + NUM_W'(1)) : mag64;
                     rsp_den_in = den64[DEN_W-1:0];
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      err_ff     <= err_in;
      cmp_ff     <= cmp_in;
      anm_ff     <= anm_in;
      adm_ff     <= adm_in;
      bnm_ff     <= bnm_in;
      bdm_ff     <= bdm_in;
      aneg_ff    <= aneg_in;
      bneg_ff    <= bneg_in;
      p1_ff      <= p1_in;
      p2_ff      <= p2_in;
      p3_ff      <= p3_in;
      mag_ff     <= mag_in;
      den_ff     <= den_in;
      g_ff       <= g_in;
      neg_ff     <= neg_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_cmp_ff <= rsp_cmp_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = rsp_num_ff;
   assign rsp_res_den  = rsp_den_ff;
   assign rsp_cmp_true = rsp_cmp_ff;
   assign rsp_error    = rsp_err_ff;

   // an accepted item starts the products or goes straight to the result on error
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_MUL_A) || (state_ff == ST_FIN))
      else $error("accepted item did not start");

   // gcd unit finishes only while the sequencer waits for it
   a_gcd_done: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> (state_ff == ST_GCD_WAIT))
      else $error("gcd done out of sequence");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVN_WAIT) || (state_ff == ST_DIVD_WAIT))
      else $error("divider done out of sequence");

   // error results carry zero payload
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_err_ff != ERR_OK) |->
         (rsp_num_ff == '0) && (rsp_den_ff == '0) && !rsp_cmp_ff)
      else $error("error result with nonzero payload");

   // a reduced arithmetic result always has a nonzero denominator
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVD_WAIT) && div_done |-> (div_q != '0))
      else $error("zero reduced denominator");
endmodule

// File: src/rfa_mul.sv
// Registered unsigned magnitude multiplier shared by all product steps.
module rfa_mul #(
   parameter int unsigned WIDTH = rfa_pkg::DEF_WIDTH
) (
   input  logic               clock,
   input  logic [WIDTH-1:0]   op_a,
   input  logic [WIDTH-1:0]   op_b,
   output logic [2*WIDTH-1:0] prod
);
   logic [2*WIDTH-1:0] prod_ff;
   logic [2*WIDTH-1:0] prod_in;

   // one product per cycle, result available in the following cycle
   assign prod_in = (2*WIDTH)'(op_a) * (2*WIDTH)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;
endmodule

// File: src/rfa_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle.
module rfa_gcd #(
   parameter int unsigned VAL_W = rfa_pkg::NUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] x,
   input  logic [VAL_W-1:0] y,
   output logic             done,
   output logic [VAL_W-1:0] g
);
   localparam int unsigned K_W = $clog2(VAL_W) + 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VAL_W-1:0] u_ff, u_in;
   logic [VAL_W-1:0] v_ff, v_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [VAL_W-1:0] g_ff, g_in;

   // step logic
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      u_in    = u_ff;
      v_in    = v_ff;
      k_in    = k_ff;
      g_in    = g_ff;
      if (start) begin
         busy_in = 1'b1;
         u_in    = x;
         v_in    = y;
         k_in    = '0;
      end else if (busy_ff) begin
         if (u_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            g_in    = v_ff << k_ff;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in = u_ff >> 1;
            v_in = v_ff >> 1;
            k_in = k_ff + K_W'(1);
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = u_ff - v_ff;
         end else begin
            v_in = v_ff - u_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      g_ff <= g_in;
   end

   assign done = done_ff;
   assign g    = g_ff;
endmodule

// File: src/rfa_div.sv
// Restoring divider: one quotient bit per cycle.
module rfa_div #(
   parameter int unsigned VAL_W = rfa_pkg::NUM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [VAL_W-1:0] dividend,
   input  logic [VAL_W-1:0] divisor,
   output logic             done,
   output logic [VAL_W-1:0] quo
);
   localparam int unsigned CNT_W = $clog2(VAL_W) + 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0] quo_ff, quo_in;
   logic [VAL_W-1:0] dvs_ff, dvs_in;
   logic [VAL_W:0]   rem_sh;
   logic [VAL_W:0]   diff;

   assign rem_sh = {rem_ff, quo_ff[VAL_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   // shift, trial subtract, restore
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[VAL_W]) begin
            rem_in = diff[VAL_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[VAL_W-1:0];
            quo_in = {quo_ff[VAL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule
